>>> rtl/core/four_level_page_table_walker_top_macros.svh
// Assertion macros used by the page table walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FPTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FPTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fptw_pkg.sv
// ----------------------------------------------------------------------------
// fptw_pkg
// Types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fptw_pkg;

    localparam int IDX_W      = 9;
    localparam int FLAGS_W    = 12;
    localparam int ENTRY_W    = 52;
    localparam int PFN_W      = ENTRY_W - FLAGS_W;
    localparam int VPN_W      = 36;
    localparam int ALLOC_W    = 9;

    localparam logic [1:0]         LEAF_LEVEL    = 2'd3;
    localparam logic [FLAGS_W-1:0] DEFAULT_FLAGS = 12'h007;
    localparam logic [ALLOC_W-1:0] CNT_TOP       = 9'h1ff;

    localparam logic REG_ROOT       = 1'b0;
    localparam logic REG_FIRST_FREE = 1'b1;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> rtl/core/fptw_store.sv
// ----------------------------------------------------------------------------
// fptw_store
// Single-port table store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fptw_store #(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17
) (
    input  wire logic                         i_clk,
    input  wire fptw_pkg::t_mem_ctl           i_ctl,
    input  wire logic [ADDR_W-1:0]            i_addr,
    input  wire logic [fptw_pkg::ENTRY_W-1:0] i_wdata,
    output logic      [fptw_pkg::ENTRY_W-1:0] o_rdata
);
    import fptw_pkg::*;

    logic [ENTRY_W-1:0] r_mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/four_level_page_table_walker_top.sv
// A full walk runs a read and an evaluate state for each level through the single-port table
// store, then a hand-off state that moves the result into the output register; a walk that
// stops early skips the remaining levels. The walker takes one request at a time: a new request
// is taken only once the result has entered the output register, which waits while the
// previous result is still held there.
// Reset: the store is swept to zero, one entry a cycle, across all TABLE_FRAMES * 512 entries.
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Walks four-level page tables held in an on-chip store: map, unmap, translate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_top_macros.svh"

module four_level_page_table_walker_top #(
    parameter int TABLE_FRAMES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [47:0] i_virt_addr,
    input  wire logic [51:0] i_phys_addr,
    input  wire logic [11:0] i_entry_flags,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [51:0]      o_result_addr,
    output logic             o_leaf_present,
    output logic [1:0]       o_status,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fptw_pkg::*;

    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = TABLE_FRAMES * 512;

    localparam logic [PFN_W:0]      TF_WIDE   = (PFN_W + 1)'(TABLE_FRAMES);
    localparam logic [12:0]         TF_NARROW = 13'(TABLE_FRAMES);
    localparam logic [ADDR_W-1:0]   CLR_LAST  = ADDR_W'(DEPTH - 1);

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [VPN_W-1:0]     r_vpn, n_vpn;
    logic [PFN_W-1:0]     r_pfn, n_pfn;
    logic [FLAGS_W-1:0]   r_fl, n_fl;
    logic [1:0]           r_level, n_level;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [ALLOC_W-1:0]   r_next_frame, n_next_frame;
    logic [7:0]           r_root;
    logic [ALLOC_W-1:0]   r_first_free;
    logic [ENTRY_W-1:0]   r_res_addr, n_res_addr;
    logic                 r_res_present, n_res_present;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0]   r_out_addr, n_out_addr;
    logic                 r_out_present, n_out_present;
    t_status              r_out_status, n_out_status;

    t_mem_ctl             w_mem_ctl;
    logic [ADDR_W-1:0]    w_mem_addr;
    logic [ENTRY_W-1:0]   w_mem_wdata;
    logic [ENTRY_W-1:0]   w_rdata;
    logic [IDX_W-1:0]     w_idx;
    logic [FLAGS_W-1:0]   w_flags;
    logic [PFN_W-1:0]     w_pfn_rd;
    logic                 w_follow_bad;
    logic                 w_exhausted;
    logic                 w_root_bad;
    logic                 w_in_acc;
    logic                 w_alloc;
    logic                 w_apb_wr;

    fptw_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // Configuration port
    assign pready   = 1'b1;
    assign w_apb_wr = psel & penable & pwrite;

    always_comb begin
        if (paddr[1:0] != 2'b00) begin
            prdata = '0;
        end else if (paddr[2] == REG_FIRST_FREE) begin
            prdata = 32'(r_first_free);
        end else begin
            prdata = 32'(r_root);
        end
    end

    // Level index select
    always_comb begin
        case (r_level)
            2'd0:    w_idx = r_vpn[35:27];
            2'd1:    w_idx = r_vpn[26:18];
            2'd2:    w_idx = r_vpn[17:9];
            default: w_idx = r_vpn[8:0];
        endcase
    end

    assign w_flags      = (r_op == OP_MAP) ? r_fl : DEFAULT_FLAGS;
    assign w_pfn_rd     = w_rdata[ENTRY_W-1:FLAGS_W];
    assign w_follow_bad = {1'b0, w_pfn_rd} >= TF_WIDE;
    assign w_exhausted  = (13'(r_next_frame) >= TF_NARROW) || (r_next_frame == CNT_TOP);
    assign w_root_bad   = 13'(r_root) >= TF_NARROW;
    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid & o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_vpn         = r_vpn;
        n_pfn         = r_pfn;
        n_fl          = r_fl;
        n_level       = r_level;
        n_frame       = r_frame;
        n_addr        = r_addr;
        n_clr_addr    = r_clr_addr;
        n_res_addr    = r_res_addr;
        n_res_present = r_res_present;
        n_status      = r_status;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_out_addr    = r_out_addr;
        n_out_present = r_out_present;
        n_out_status  = r_out_status;
        w_alloc       = 1'b0;
        w_mem_ctl     = '0;
        w_mem_addr    = r_addr;
        w_mem_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_mem_ctl.wr_en = 1'b1;
                w_mem_addr      = r_clr_addr;
                n_clr_addr      = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op          = t_op'(i_operation);
                    n_vpn         = i_virt_addr[47:12];
                    n_pfn         = i_phys_addr[51:12];
                    n_fl          = i_entry_flags;
                    n_level       = '0;
                    n_frame       = FRAME_W'(r_root);
                    n_res_addr    = '0;
                    n_res_present = 1'b0;
                    n_status      = ST_OK;
                    if (t_op'(i_operation) == OP_NONE) begin
                        n_state = S_DONE;
                    end else if (w_root_bad) begin
                        n_status = ST_OUTSIDE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                w_mem_ctl.rd_en = 1'b1;
                w_mem_addr      = {r_frame, w_idx};
                n_addr          = {r_frame, w_idx};
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (r_level != LEAF_LEVEL) begin
                    if (w_rdata[0]) begin
                        if (w_follow_bad) begin
                            n_status = ST_OUTSIDE;
                            n_state  = S_DONE;
                        end else begin
                            n_frame = FRAME_W'(w_pfn_rd);
                            n_level = r_level + 1'b1;
                            n_state = S_READ;
                        end
                    end else if (w_exhausted) begin
                        n_status = ST_NO_FRAME;
                        n_state  = S_DONE;
                    end else begin
                        // hand out the next frame and link it in
                        w_alloc         = 1'b1;
                        w_mem_ctl.wr_en = 1'b1;
                        w_mem_wdata     = ENTRY_W'({r_next_frame, w_flags});
                        n_frame         = FRAME_W'(r_next_frame);
                        n_level         = r_level + 1'b1;
                        n_state         = S_READ;
                    end
                end else begin
                    case (r_op)
                        OP_MAP: begin
                            w_mem_ctl.wr_en = 1'b1;
                            w_mem_wdata     = {r_pfn, r_fl};
                            n_res_present   = r_fl[0];
                        end
                        OP_UNMAP: begin
                            w_mem_ctl.wr_en = 1'b1;
                        end
                        OP_XLATE: begin
                            if (w_rdata[0]) begin
                                n_res_addr    = {w_pfn_rd, {FLAGS_W{1'b0}}};
                                n_res_present = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_addr    = r_res_addr;
                    n_out_present = r_res_present;
                    n_out_status  = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next_frame = r_next_frame;
        if (w_apb_wr && (paddr[2] == REG_FIRST_FREE)) begin
            n_next_frame = pwdata[ALLOC_W-1:0];
        end else if (w_alloc) begin
            n_next_frame = r_next_frame + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_root       <= '0;
            r_first_free <= 9'd1;
            r_next_frame <= 9'd1;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
            r_next_frame <= n_next_frame;
            if (w_apb_wr && (paddr[2] == REG_ROOT)) begin
                r_root <= pwdata[7:0];
            end
            if (w_apb_wr && (paddr[2] == REG_FIRST_FREE)) begin
                r_first_free <= pwdata[ALLOC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_vpn         <= n_vpn;
        r_pfn         <= n_pfn;
        r_fl          <= n_fl;
        r_level       <= n_level;
        r_frame       <= n_frame;
        r_addr        <= n_addr;
        r_res_addr    <= n_res_addr;
        r_res_present <= n_res_present;
        r_status      <= n_status;
        r_out_addr    <= n_out_addr;
        r_out_present <= n_out_present;
        r_out_status  <= n_out_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_addr  = r_out_addr;
    assign o_leaf_present = r_out_present;
    assign o_status       = r_out_status;

    `FPTW_ASSERT_NOW(a_wr_only_clear_or_eval, i_clk, i_rst_n, w_mem_ctl.wr_en,
        (r_state == S_CLEAR) || (r_state == S_EVAL), "store written outside clear or evaluate")
    `FPTW_ASSERT_NOW(a_no_frame_means_exhausted, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_status == ST_NO_FRAME), w_exhausted,
        "no-frame status with frames left")
    `FPTW_ASSERT_NEXT(a_accept_starts_walk, i_clk, i_rst_n, w_in_acc,
        (r_state == S_READ) || (r_state == S_DONE), "accepted transaction did not start a walk")
    `FPTW_ASSERT_NOW(a_alloc_not_exhausted, i_clk, i_rst_n, w_alloc,
        !w_exhausted && (r_level != LEAF_LEVEL), "frame handed out from an exhausted allocator")

endmodule

`default_nettype wire
